// ===== design/gdhsh_pkg.sv =====
// Shared types and constants of the gated dual-hit spectrum histogrammer.
package gdhsh_pkg;

   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 40;

   // 1/16-count ADC over 4096 counts spans 2^16
   localparam int ADC_SPAN_SHIFT = 16;
   localparam int ADC_W          = 20;
   localparam int MODULE_W       = 5;
   localparam int CHANNEL_W      = 6;
   localparam int READ_BIN_W     = 7;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET_MODULE = 3'd0,
      CSR_TEMP_LOW      = 3'd1,
      CSR_TEMP_HIGH     = 3'd2,
      CSR_VOLT_LOW      = 3'd3,
      CSR_VOLT_HIGH     = 3'd4,
      CSR_INTERVAL_MAX  = 3'd5,
      CSR_ADC_FLOOR     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [MODULE_W-1:0] target_module;
      logic signed [11:0]  temp_low;
      logic signed [11:0]  temp_high;
      logic [15:0]         volt_low;
      logic [15:0]         volt_high;
      logic [15:0]         interval_max;
      logic [ADC_W-1:0]    adc_floor;
   } cfg_type;

   localparam logic [MODULE_W-1:0] RST_TARGET_MODULE = 5'd0;
   localparam logic signed [11:0]  RST_TEMP_LOW      = -12'sd2048;
   localparam logic signed [11:0]  RST_TEMP_HIGH     = 12'sd2047;
   localparam logic [15:0]         RST_VOLT_LOW      = 16'd0;
   localparam logic [15:0]         RST_VOLT_HIGH     = 16'd65535;
   localparam logic [15:0]         RST_INTERVAL_MAX  = 16'd320;
   localparam logic [ADC_W-1:0]    RST_ADC_FLOOR     = 20'd6400;

   // decoded request handed from the front stage to the sequencer
   typedef struct packed {
      logic is_read;
      logic kept;
      logic hit_a;
      logic hit_b;
      logic read_ok;
      logic same_addr;
   } job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_WR_B,
      ST_DONE
   } state_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      return (value == '1) ? value : value + COUNT_W'(1);
   endfunction

endpackage

// ===== design/gdhsh_csr.sv =====
// Configuration registers of the histogrammer.
module gdhsh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [gdhsh_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gdhsh_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output gdhsh_pkg::cfg_type                  cfg
);

   gdhsh_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (gdhsh_pkg::csr_index_type'(csr_addr))
            gdhsh_pkg::CSR_TARGET_MODULE: cfg_in.target_module = csr_wdata[4:0];
            gdhsh_pkg::CSR_TEMP_LOW:      cfg_in.temp_low      = csr_wdata[11:0];
            gdhsh_pkg::CSR_TEMP_HIGH:     cfg_in.temp_high     = csr_wdata[11:0];
            gdhsh_pkg::CSR_VOLT_LOW:      cfg_in.volt_low      = csr_wdata[15:0];
            gdhsh_pkg::CSR_VOLT_HIGH:     cfg_in.volt_high     = csr_wdata[15:0];
            gdhsh_pkg::CSR_INTERVAL_MAX:  cfg_in.interval_max  = csr_wdata[15:0];
            gdhsh_pkg::CSR_ADC_FLOOR:     cfg_in.adc_floor     = csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_module <= gdhsh_pkg::RST_TARGET_MODULE;
         cfg_ff.temp_low      <= gdhsh_pkg::RST_TEMP_LOW;
         cfg_ff.temp_high     <= gdhsh_pkg::RST_TEMP_HIGH;
         cfg_ff.volt_low      <= gdhsh_pkg::RST_VOLT_LOW;
         cfg_ff.volt_high     <= gdhsh_pkg::RST_VOLT_HIGH;
         cfg_ff.interval_max  <= gdhsh_pkg::RST_INTERVAL_MAX;
         cfg_ff.adc_floor     <= gdhsh_pkg::RST_ADC_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/gdhsh_front.sv =====
// Request decode stage: window gating, hit selection, bin and address calculation.
module gdhsh_front #(
   parameter int CHANNELS = 64,
   parameter int BINS     = 64,
   parameter int MODULES  = 25,
   parameter int AW       = 13
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic                                req_cmd,
   input  logic [gdhsh_pkg::REQ_DATA_W-1:0]    req_data,
   input  gdhsh_pkg::cfg_type                  cfg,
   output gdhsh_pkg::job_type                  job,
   output logic [AW-1:0]                       addr_a,
   output logic [AW-1:0]                       addr_b
);

   localparam int BW   = $clog2(BINS + 1);
   localparam int PW   = gdhsh_pkg::ADC_W + BW;
   localparam int QW   = PW - gdhsh_pkg::ADC_SPAN_SHIFT;
   localparam int SELW = (BW > gdhsh_pkg::READ_BIN_W) ? BW : gdhsh_pkg::READ_BIN_W;
   localparam int SW   = AW + 2;

   logic [15:0]                          interval;
   logic signed [11:0]                   temperature;
   logic [15:0]                          voltage;
   logic [gdhsh_pkg::MODULE_W-1:0]       first_module, second_module;
   logic [gdhsh_pkg::CHANNEL_W-1:0]      first_channel, second_channel;
   logic [gdhsh_pkg::ADC_W-1:0]          first_adc, second_adc;
   logic [1:0]                           bad_flags;
   logic [gdhsh_pkg::READ_BIN_W-1:0]     read_bin;

   logic                                 target_ok, kept, hit_a, hit_b, read_ok;
   logic [PW-1:0]                        prod_a, prod_b;
   logic [QW-1:0]                        quot_a, quot_b;
   logic [BW-1:0]                        bin_a, bin_b;
   logic [SELW-1:0]                      sel_bin_a;
   logic [SW-1:0]                        sum_a, sum_b;

   gdhsh_pkg::job_type                   job_ff, job_in;
   logic [AW-1:0]                        addr_a_ff, addr_b_ff, addr_a_in, addr_b_in;

   assign interval       = req_data[15:0];
   assign temperature    = req_data[27:16];
   assign voltage        = req_data[43:28];
   assign first_module   = req_data[48:44];
   assign first_channel  = req_data[54:49];
   assign first_adc      = req_data[74:55];
   assign second_module  = req_data[79:75];
   assign second_channel = req_data[85:80];
   assign second_adc     = req_data[105:86];
   assign bad_flags      = req_data[107:106];
   assign read_bin       = req_data[114:108];

   always_comb begin
      target_ok = 32'(cfg.target_module) < MODULES;
      kept = !req_cmd && (interval <= cfg.interval_max)
             && (temperature >= cfg.temp_low) && (temperature <= cfg.temp_high)
             && (voltage >= cfg.volt_low) && (voltage <= cfg.volt_high);
      hit_a = kept && target_ok && (first_module == cfg.target_module) && !bad_flags[0]
              && (first_adc > cfg.adc_floor) && (32'(first_channel) < CHANNELS);
      hit_b = kept && target_ok && (second_module == cfg.target_module) && !bad_flags[1]
              && (second_adc > cfg.adc_floor) && (32'(second_channel) < CHANNELS);
      read_ok = (32'(first_channel) < CHANNELS) && (32'(read_bin) <= BINS);

      // bin = floor(adc * BINS / 2^16), anything past the range lands in bin BINS
      prod_a = PW'(first_adc) * PW'(BINS);
      prod_b = PW'(second_adc) * PW'(BINS);
      quot_a = prod_a[PW-1:gdhsh_pkg::ADC_SPAN_SHIFT];
      quot_b = prod_b[PW-1:gdhsh_pkg::ADC_SPAN_SHIFT];
      bin_a  = (quot_a > QW'(BINS)) ? BW'(BINS) : quot_a[BW-1:0];
      bin_b  = (quot_b > QW'(BINS)) ? BW'(BINS) : quot_b[BW-1:0];

      sel_bin_a = req_cmd ? SELW'(read_bin) : SELW'(bin_a);
      sum_a = SW'(first_channel) * SW'(BINS + 1) + SW'(sel_bin_a);
      sum_b = SW'(second_channel) * SW'(BINS + 1) + SW'(bin_b);
      addr_a_in = sum_a[AW-1:0];
      addr_b_in = sum_b[AW-1:0];

      job_in.is_read   = req_cmd;
      job_in.kept      = kept;
      job_in.hit_a     = hit_a;
      job_in.hit_b     = hit_b;
      job_in.read_ok   = read_ok;
      job_in.same_addr = (addr_a_in == addr_b_in);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff    <= job_in;
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
      end
   end

   assign job    = job_ff;
   assign addr_a = addr_a_ff;
   assign addr_b = addr_b_ff;

endmodule

// ===== design/gdhsh_ram.sv =====
// Histogram count memory: one write port, one read port, registered read data.
module gdhsh_ram #(
   parameter int DEPTH = 4160,
   parameter int AW    = 13
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [gdhsh_pkg::COUNT_W-1:0]    wr_data,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr,
   output logic [gdhsh_pkg::COUNT_W-1:0]    rd_data
);

   logic [gdhsh_pkg::COUNT_W-1:0] mem [DEPTH];
   logic [gdhsh_pkg::COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gated_dual_hit_spectrum_histogram.sv =====
// Top level of the gated dual-hit spectrum histogrammer: sequencer and result register.
//
//  channel | ports        | moves
//  --------+--------------+-----------------------------------------------
//  request | req_t*       | event (tuser 0) or bin read (tuser 1)
//  result  | rsp_t*       | event_kept, hits_filled, bin_count
//  config  | csr_*        | register writes, index = list position
//
// An event passes through states RD_A, RD_B, WR_B and DONE after acceptance (two
// read-modify-writes of the count memory through its single read port); a bin read
// skips WR_B. After reset a clearing pass writes zero to all CHANNELS*(BINS+1)
// counts, one per cycle (4160 counts at default size), with req_tready low.
// A result waiting on rsp_tready does not block acceptance of the next
// request; that request stalls only at its own result stage.
module gated_dual_hit_spectrum_histogram #(
   parameter int CHANNELS = 64,
   parameter int BINS     = 64,
   parameter int MODULES  = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tuser: cmd
   input  logic                                req_tuser,
   // tdata from bit 0: interval, temperature, voltage, first_module, first_channel,
   // first_adc, second_module, second_channel, second_adc, bad_flags, read_bin
   input  logic [gdhsh_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata from bit 0: event_kept, hits_filled, bin_count
   output logic [gdhsh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wen,
   input  logic [gdhsh_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gdhsh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH = CHANNELS * (BINS + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = gdhsh_pkg::COUNT_W;

   gdhsh_pkg::cfg_type    cfg;
   gdhsh_pkg::job_type    job;
   gdhsh_pkg::state_type  state_ff, state_in;

   logic [AW-1:0]  addr_a, addr_b;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]  inc_a_ff, inc_a_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           accept;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [CW-1:0]  wr_data, rd_data, data_b;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_kept_ff, rsp_kept_in;
   logic [1:0]     rsp_hits_ff, rsp_hits_in;
   logic [CW-1:0]  rsp_count_ff, rsp_count_in;
   logic           rsp_load;

   gdhsh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gdhsh_front #(
      .CHANNELS (CHANNELS),
      .BINS     (BINS),
      .MODULES  (MODULES),
      .AW       (AW)
   ) u_front (
      .clock    (clock),
      .load     (accept),
      .req_cmd  (req_tuser),
      .req_data (req_tdata),
      .cfg      (cfg),
      .job      (job),
      .addr_a   (addr_a),
      .addr_b   (addr_b)
   );

   gdhsh_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // second hit on the bin just written by the first: take the written value
   assign data_b = (job.hit_a && job.same_addr) ? inc_a_ff : rd_data;
   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdhsh_pkg::ST_CLEAR: if (clr_cnt_ff == AW'(DEPTH - 1)) state_in = gdhsh_pkg::ST_IDLE;
         gdhsh_pkg::ST_IDLE:  if (req_tvalid) state_in = gdhsh_pkg::ST_RD_A;
         gdhsh_pkg::ST_RD_A:  state_in = gdhsh_pkg::ST_RD_B;
         gdhsh_pkg::ST_RD_B: begin
            state_in = job.is_read ? gdhsh_pkg::ST_DONE : gdhsh_pkg::ST_WR_B;
         end
         gdhsh_pkg::ST_WR_B:  state_in = gdhsh_pkg::ST_DONE;
         gdhsh_pkg::ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = gdhsh_pkg::ST_IDLE;
         default:             state_in = gdhsh_pkg::ST_CLEAR;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = addr_a;
      wr_en        = 1'b0;
      wr_addr      = addr_a;
      wr_data      = gdhsh_pkg::sat_inc(rd_data);
      clr_cnt_in   = clr_cnt_ff;
      inc_a_in     = inc_a_ff;
      count_in     = count_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         gdhsh_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         gdhsh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         gdhsh_pkg::ST_RD_A: begin
            rd_en = 1'b1;
         end
         gdhsh_pkg::ST_RD_B: begin
            count_in = (job.is_read && job.read_ok) ? rd_data : '0;
            inc_a_in = gdhsh_pkg::sat_inc(rd_data);
            wr_en    = !job.is_read && job.hit_a;
            rd_en    = !job.is_read;
            rd_addr  = addr_b;
         end
         gdhsh_pkg::ST_WR_B: begin
            wr_en   = job.hit_b;
            wr_addr = addr_b;
            wr_data = gdhsh_pkg::sat_inc(data_b);
         end
         gdhsh_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kept_in  = rsp_kept_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kept_in  = job.kept;
         rsp_hits_in  = {1'b0, job.hit_a} + {1'b0, job.hit_b};
         rsp_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdhsh_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_a_ff     <= inc_a_in;
      count_ff     <= count_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_hits_ff  <= rsp_hits_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff, rsp_hits_ff, rsp_kept_ff};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the gated dual-hit spectrum histogrammer.
`timescale 1ns / 100ps

module testbench;

   localparam int CHANNELS       = 64;
   localparam int BINS           = 64;
   localparam int MODULES        = 25;
   localparam int SLOTS          = CHANNELS * (BINS + 1);
   localparam int ITEMS_PER_SET  = 86;
   localparam int SETTINGS_COUNT = 7;
   localparam int QUIET_LIMIT    = 20000;
   localparam int TAIL_CYCLES    = 20;

   typedef struct packed {
      logic               cmd;
      logic [15:0]        interval;
      logic signed [11:0] temperature;
      logic [15:0]        voltage;
      logic [4:0]         first_module;
      logic [5:0]         first_channel;
      logic [19:0]        first_adc;
      logic [4:0]         second_module;
      logic [5:0]         second_channel;
      logic [19:0]        second_adc;
      logic [1:0]         bad_flags;
      logic [6:0]         read_bin;
   } hist_request_type;

   typedef struct packed {
      logic        kept;
      logic [1:0]  hits;
      logic [31:0] count;
   } hist_result_type;

   typedef struct packed {
      hist_request_type rq;
      logic             typed;
      hist_result_type  want;
   } stim_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic                             req_tuser;
   logic [gdhsh_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [gdhsh_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_wen;
   logic [gdhsh_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [gdhsh_pkg::CSR_DATA_W-1:0] csr_wdata;

   // shadow of the block's registers and count store
   logic [4:0]         target_module;
   logic signed [11:0] temp_low;
   logic signed [11:0] temp_high;
   logic [15:0]        volt_low;
   logic [15:0]        volt_high;
   logic [15:0]        interval_max;
   logic [19:0]        adc_floor;
   logic [31:0]        spectrum_counts [SLOTS];

   hist_result_type pending_responses [$];

   bit steady_flow;
   int stall_left;
   int quiet_cycles;
   int mismatches;
   int n_events, n_kept, n_hits, n_reads, n_nonzero_reads;

   gated_dual_hit_spectrum_histogram #(
      .CHANNELS (CHANNELS),
      .BINS     (BINS),
      .MODULES  (MODULES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int count_hit(logic [4:0] module_no, logic [5:0] channel,
                                    logic [19:0] adc, logic bad);
      int bin_no;
      int slot;
      if (int'(target_module) >= MODULES) return 0;
      if (module_no != target_module) return 0;
      if (bad) return 0;
      if (adc <= adc_floor) return 0;
      if (int'(channel) >= CHANNELS) return 0;
      bin_no = (int'(adc) * BINS) >> gdhsh_pkg::ADC_SPAN_SHIFT;
      if (bin_no > BINS) bin_no = BINS;
      slot = int'(channel) * (BINS + 1) + bin_no;
      if (spectrum_counts[slot] != '1) spectrum_counts[slot] = spectrum_counts[slot] + 1;
      return 1;
   endfunction

   function automatic hist_result_type predict_response(hist_request_type rq);
      hist_result_type res;
      int hits;
      res = '0;
      hits = 0;
      if (!rq.cmd) begin
         if (rq.interval <= interval_max &&
             $signed(rq.temperature) >= temp_low && $signed(rq.temperature) <= temp_high &&
             rq.voltage >= volt_low && rq.voltage <= volt_high) begin
            res.kept = 1'b1;
            hits += count_hit(rq.first_module, rq.first_channel, rq.first_adc,
                              rq.bad_flags[0]);
            hits += count_hit(rq.second_module, rq.second_channel, rq.second_adc,
                              rq.bad_flags[1]);
         end
         res.hits = 2'(hits);
      end else if (int'(rq.first_channel) < CHANNELS && int'(rq.read_bin) <= BINS) begin
         res.count = spectrum_counts[int'(rq.first_channel) * (BINS + 1) + int'(rq.read_bin)];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- random items

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(80, 20);
   endfunction

   // uniform inside [lo, hi], with the bounds themselves favored
   function automatic int pick_in(int lo, int hi);
      int r;
      r = $urandom_range(9);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // few channels so that reads find filled bins
   function automatic logic [5:0] pick_channel();
      return ($urandom_range(9) < 7) ? 6'($urandom_range(7)) : 6'($urandom);
   endfunction

   function automatic logic [19:0] pick_adc();
      int r;
      r = $urandom_range(9);
      if (r < 5) return 20'($urandom_range(65535));
      if (r < 8) return 20'($urandom_range(131071));
      if (r < 9) return 20'($urandom);
      return adc_floor + 20'($urandom_range(1));
   endfunction

   function automatic hist_request_type random_request();
      hist_request_type rq;
      int kind;
      kind = $urandom_range(99);
      rq.cmd            = 1'($urandom);
      rq.interval       = 16'($urandom);
      rq.temperature    = 12'($urandom);
      rq.voltage        = 16'($urandom);
      rq.first_module   = 5'($urandom);
      rq.first_channel  = 6'($urandom);
      rq.first_adc      = 20'($urandom);
      rq.second_module  = 5'($urandom);
      rq.second_channel = 6'($urandom);
      rq.second_adc     = 20'($urandom);
      rq.bad_flags      = 2'($urandom);
      rq.read_bin       = 7'($urandom);
      if (kind < 60) begin
         // event shaped to pass the windows where they are not empty
         rq.cmd      = 1'b0;
         rq.interval = 16'(pick_in(0, int'(interval_max)));
         if (temp_low <= temp_high)
            rq.temperature = 12'(pick_in(int'(temp_low), int'(temp_high)));
         if (volt_low <= volt_high)
            rq.voltage = 16'(pick_in(int'(volt_low), int'(volt_high)));
         if ($urandom_range(9) < 8) rq.first_module = target_module;
         if ($urandom_range(9) < 8) rq.second_module = target_module;
         rq.first_channel  = pick_channel();
         rq.second_channel = ($urandom_range(3) == 0) ? rq.first_channel : pick_channel();
         rq.first_adc      = pick_adc();
         rq.second_adc     = ($urandom_range(4) == 0) ? rq.first_adc : pick_adc();
         if ($urandom_range(9) < 7) rq.bad_flags = 2'b00;
      end else if (kind < 85) begin
         rq.cmd           = 1'b1;
         rq.first_channel = pick_channel();
         rq.read_bin      = ($urandom_range(9) < 9) ? 7'($urandom_range(BINS))
                                                    : 7'($urandom_range(127, BINS + 1));
      end
      return rq;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_request(hist_request_type rq, logic typed, hist_result_type want);
      int gap;
      hist_result_type res;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = rq.cmd;
      req_tdata  = {5'd0, rq.read_bin, rq.bad_flags, rq.second_adc, rq.second_channel,
                    rq.second_module, rq.first_adc, rq.first_channel, rq.first_module,
                    rq.voltage, rq.temperature, rq.interval};
      do @(posedge clock); while (!req_tready);
      res = predict_response(rq);
      pending_responses.push_back(typed ? want : res);
      if (rq.cmd) begin
         n_reads++;
         if (res.count != 0) n_nonzero_reads++;
      end else begin
         n_events++;
         n_kept += res.kept;
         n_hits += res.hits;
      end
   endtask

   // sender holds off until every result is back
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(gdhsh_pkg::csr_index_type idx, logic [19:0] value);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         gdhsh_pkg::CSR_TARGET_MODULE: target_module = value[4:0];
         gdhsh_pkg::CSR_TEMP_LOW:      temp_low      = $signed(value[11:0]);
         gdhsh_pkg::CSR_TEMP_HIGH:     temp_high     = $signed(value[11:0]);
         gdhsh_pkg::CSR_VOLT_LOW:      volt_low      = value[15:0];
         gdhsh_pkg::CSR_VOLT_HIGH:     volt_high     = value[15:0];
         gdhsh_pkg::CSR_INTERVAL_MAX:  interval_max  = value[15:0];
         gdhsh_pkg::CSR_ADC_FLOOR:     adc_floor     = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [4:0] tm, int tlo, int thi, int vlo, int vhi,
                                 int imax, int afloor);
      write_register(gdhsh_pkg::CSR_TARGET_MODULE, 20'(tm));
      write_register(gdhsh_pkg::CSR_TEMP_LOW, 20'(tlo));
      write_register(gdhsh_pkg::CSR_TEMP_HIGH, 20'(thi));
      write_register(gdhsh_pkg::CSR_VOLT_LOW, 20'(vlo));
      write_register(gdhsh_pkg::CSR_VOLT_HIGH, 20'(vhi));
      write_register(gdhsh_pkg::CSR_INTERVAL_MAX, 20'(imax));
      write_register(gdhsh_pkg::CSR_ADC_FLOOR, 20'(afloor));
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side

   always @(negedge clock) begin
      if (steady_flow) begin
         rsp_tready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         if ($urandom_range(99) < 30) stall_left = pick_gap() + 1;
      end
   end

   always @(posedge clock) begin
      hist_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("result with no request outstanding: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[0] !== want.kept) begin
               $error("event_kept mismatch: expected %0d, got %0d", want.kept, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[2:1] !== want.hits) begin
               $error("hits_filled mismatch: expected %0d, got %0d", want.hits,
                      rsp_tdata[2:1]);
               mismatches++;
            end
            if (rsp_tdata[34:3] !== want.count) begin
               $error("bin_count mismatch: expected %0d, got %0d", want.count,
                      rsp_tdata[34:3]);
               mismatches++;
            end
         end
      end
   end

   // watchdog: covers the clearing pass after reset plus the longest stalls
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // defaults: target 0, full windows, interval_max 320, adc_floor 6400 (bin 6 just above)
   stim_row_type directed_rows [0:19] = '{
      // reads right after reset come back empty
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd0, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd0},
        1'b1, '{1'b0, 2'd0, 32'd0}},
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd63, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd64},
        1'b1, '{1'b0, 2'd0, 32'd0}},
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd5, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd127},
        1'b1, '{1'b0, 2'd0, 32'd0}},
      // both hits in one bin, lowest window edges
      '{'{1'b0, 16'd0, -12'sd2048, 16'd0, 5'd0, 6'd0, 20'd6401, 5'd0, 6'd0, 20'd6401,
          2'd0, 7'd0}, 1'b0, '0},
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd0, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd6},
        1'b0, '0},
      // highest window edges, overflow bin and top regular bin
      '{'{1'b0, 16'd320, 12'sd2047, 16'd65535, 5'd0, 6'd63, 20'd1048575, 5'd0, 6'd63,
          20'd65535, 2'd0, 7'd0}, 1'b0, '0},
      // interval just past the limit, and at its maximum
      '{'{1'b0, 16'd321, 12'sd0, 16'd100, 5'd0, 6'd0, 20'd6401, 5'd0, 6'd0, 20'd6401,
          2'd0, 7'd0}, 1'b1, '{1'b0, 2'd0, 32'd0}},
      '{'{1'b0, 16'd65535, 12'sd0, 16'd100, 5'd0, 6'd0, 20'd6401, 5'd0, 6'd0, 20'd6401,
          2'd0, 7'd0}, 1'b1, '{1'b0, 2'd0, 32'd0}},
      // ADC equal to the floor is not counted
      '{'{1'b0, 16'd10, 12'sd5, 16'd100, 5'd0, 6'd2, 20'd6400, 5'd0, 6'd2, 20'd6401,
          2'd0, 7'd0}, 1'b0, '0},
      // bad hits
      '{'{1'b0, 16'd10, 12'sd5, 16'd100, 5'd0, 6'd3, 20'd9000, 5'd0, 6'd3, 20'd9000,
          2'd3, 7'd0}, 1'b0, '0},
      '{'{1'b0, 16'd10, 12'sd5, 16'd100, 5'd0, 6'd3, 20'd9000, 5'd0, 6'd3, 20'd20000,
          2'd1, 7'd0}, 1'b0, '0},
      '{'{1'b0, 16'd10, 12'sd5, 16'd100, 5'd0, 6'd3, 20'd9000, 5'd0, 6'd3, 20'd20000,
          2'd2, 7'd0}, 1'b0, '0},
      // hits on other modules
      '{'{1'b0, 16'd10, 12'sd5, 16'd100, 5'd24, 6'd4, 20'd9000, 5'd31, 6'd4, 20'd9000,
          2'd0, 7'd0}, 1'b0, '0},
      // either side of the overflow boundary
      '{'{1'b0, 16'd10, -12'sd5, 16'd100, 5'd0, 6'd1, 20'd65535, 5'd0, 6'd1, 20'd65536,
          2'd0, 7'd0}, 1'b0, '0},
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd63, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd64},
        1'b0, '0},
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd63, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd63},
        1'b0, '0},
      // bin just past the overflow bin
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd0, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd65},
        1'b1, '{1'b0, 2'd0, 32'd0}},
      // read with every unused field set
      '{'{1'b1, 16'd65535, -12'sd1, 16'd65535, 5'd31, 6'd1, 20'd1048575, 5'd31, 6'd63,
          20'd1048575, 2'd3, 7'd64}, 1'b0, '0},
      // event with a junk read_bin and zero ADC
      '{'{1'b0, 16'd1, 12'sd0, 16'd1, 5'd0, 6'd9, 20'd0, 5'd0, 6'd9, 20'd0, 2'd0, 7'd127},
        1'b0, '0},
      '{'{1'b1, 16'd0, 12'sd0, 16'd0, 5'd0, 6'd1, 20'd0, 5'd0, 6'd0, 20'd0, 2'd0, 7'd63},
        1'b0, '0}
   };

   initial begin
      int tlo, thi, vlo, vhi;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      stall_left = 0;
      quiet_cycles = 0;
      mismatches = 0;
      steady_flow = 1'b0;
      n_events = 0;
      n_kept = 0;
      n_hits = 0;
      n_reads = 0;
      n_nonzero_reads = 0;
      target_module = gdhsh_pkg::RST_TARGET_MODULE;
      temp_low      = gdhsh_pkg::RST_TEMP_LOW;
      temp_high     = gdhsh_pkg::RST_TEMP_HIGH;
      volt_low      = gdhsh_pkg::RST_VOLT_LOW;
      volt_high     = gdhsh_pkg::RST_VOLT_HIGH;
      interval_max  = gdhsh_pkg::RST_INTERVAL_MAX;
      adc_floor     = gdhsh_pkg::RST_ADC_FLOOR;
      foreach (spectrum_counts[i]) spectrum_counts[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      drain();

      for (int s = 0; s < SETTINGS_COUNT; s++) begin
         case (s)
            0: apply_settings(5'd0, -2048, 2047, 0, 65535, 65535, 0);
            1: begin
               tlo = int'($urandom_range(600)) - 300;
               thi = tlo + int'($urandom_range(400));
               vlo = $urandom_range(40000);
               vhi = vlo + int'($urandom_range(20000));
               apply_settings(5'd24, tlo, thi, vlo, vhi, $urandom_range(2000),
                              $urandom_range(8000));
            end
            // empty temperature window
            2: apply_settings(5'($urandom_range(MODULES - 1)), 2047, -2048, 0, 65535,
                              65535, $urandom_range(8000));
            // target module beyond the last module, empty voltage window
            3: apply_settings(5'd31, -2048, 2047, 65535, 0, 0, 1048575);
            4: begin
               vlo = $urandom_range(65535);
               apply_settings(5'($urandom_range(MODULES - 1)), -2048, 2047, vlo, vlo, 0,
                              1048575);
            end
            5: apply_settings(5'($urandom), int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048, $urandom_range(65535),
                              $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(70000));
            default: apply_settings(5'd7, -2048, 2047, 0, 65535, 320, 6400);
         endcase
         steady_flow = (s == 0);
         repeat (ITEMS_PER_SET) send_request(random_request(), 1'b0, '0);
         drain();
      end

      steady_flow = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d events (%0d kept, %0d hits counted) and %0d bin reads (%0d nonzero)",
               n_events, n_kept, n_hits, n_reads, n_nonzero_reads);
      $display("under reset defaults and %0d register settings", SETTINGS_COUNT);
      if (mismatches == 0 && pending_responses.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
